[rtl/ppdm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ppdm_pkg;

   // frame geometry
   localparam int FRAME_WIDTH  = 640;
   localparam int FRAME_HEIGHT = 480;
   localparam int CELL_COUNT   = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int CELL_AW      = $clog2(CELL_COUNT);

   // field widths
   localparam int COL_W   = 10;
   localparam int ROW_W   = 9;
   localparam int INDEX_W = 19;
   localparam int DATA_W  = 32;

   // divider
   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   typedef enum logic {
      CMD_SPLAT = 1'b0,
      CMD_READ  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      STATUS_FIRST      = 3'd0,
      STATUS_REPLACED   = 3'd1,
      STATUS_KEPT       = 3'd2,
      STATUS_BAD_W      = 3'd3,
      STATUS_OUT        = 3'd4,
      STATUS_READ_HIT   = 3'd5,
      STATUS_READ_EMPTY = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV_COL,
      S_DIV_ROW,
      S_ADDR,
      S_READ,
      S_DECIDE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic                     valid;
      logic [INDEX_W-1:0]       index;
      logic signed [DATA_W-1:0] depth;
   } cell_type;

   localparam int CELL_W = $bits(cell_type);

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic [DATA_W-1:0] magnitude(input logic signed [DATA_W-1:0] x);
      logic [DATA_W-1:0] r;
      r = x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/ppdm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module ppdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/ppdm_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
module ppdm_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ppdm_pkg::DATA_W-1:0]   dividend,
   input  wire logic [ppdm_pkg::DATA_W-1:0]   divisor,
   output ppdm_pkg::div_status_type           status,
   output logic      [ppdm_pkg::DATA_W-1:0]   quotient
);

   // restoring division, one quotient bit a cycle, unsigned magnitudes
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [ppdm_pkg::DIV_CW-1:0]       count_ff, count_in;
   logic [ppdm_pkg::DATA_W-1:0]       quo_ff, quo_in;
   logic [ppdm_pkg::DATA_W-1:0]       rem_ff, rem_in;
   logic [ppdm_pkg::DATA_W-1:0]       dsr_ff, dsr_in;
   logic [ppdm_pkg::DATA_W:0]         shifted;
   logic [ppdm_pkg::DATA_W:0]         diff;
   logic                              last_step;

   assign shifted   = {rem_ff, quo_ff[ppdm_pkg::DATA_W-1]};
   assign diff      = shifted - {1'b0, dsr_ff};
   assign last_step = (count_ff == ppdm_pkg::DIV_CW'(ppdm_pkg::DIV_STEPS - 1));

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (!diff[ppdm_pkg::DATA_W]) begin
            rem_in = diff[ppdm_pkg::DATA_W-1:0];
            quo_in = {quo_ff[ppdm_pkg::DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[ppdm_pkg::DATA_W-1:0];
            quo_in = {quo_ff[ppdm_pkg::DATA_W-2:0], 1'b0};
         end
         count_in = count_ff + ppdm_pkg::DIV_CW'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule
`default_nettype wire

[rtl/projected_point_depth_map.sv]
`timescale 1ns / 1ps
`default_nettype none
// projected point depth map: each splat word carries a homogeneous point (u, v, w) in
// signed q16.16; the pixel is column u/w, row v/w, truncated toward zero, and the map
// keeps per pixel the point with the smallest w (ties keep the stored point). a read word
// returns the entry at a given pixel. every word gives exactly one response word.
// after reset the block sweeps the whole map empty, one pixel a cycle, and takes no
// request word until the sweep is done. a splat that lands in the frame runs the single
// 32-step restoring divider twice (column, then row), one quotient bit a cycle,
// followed by an address multiply, a map read, the update and the hand-over. a splat
// that lands off the frame skips the multiply, read and update; a read word or a splat
// with a bad w skips the divider. the hand-over waits while the output is stalled.
// one word is in work at a time; a finished response waits in the output register while
// the next word is accepted.
module projected_point_depth_map (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_cmd,
   input  wire logic signed [ppdm_pkg::DATA_W-1:0]   req_proj_u,
   input  wire logic signed [ppdm_pkg::DATA_W-1:0]   req_proj_v,
   input  wire logic signed [ppdm_pkg::DATA_W-1:0]   req_proj_w,
   input  wire logic                                 req_w_is_number,
   input  wire logic [ppdm_pkg::INDEX_W-1:0]         req_point_index,
   input  wire logic [ppdm_pkg::COL_W-1:0]           req_read_col,
   input  wire logic [ppdm_pkg::ROW_W-1:0]           req_read_row,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [2:0]                                rsp_status,
   output logic [ppdm_pkg::COL_W-1:0]                rsp_pixel_col,
   output logic [ppdm_pkg::ROW_W-1:0]                rsp_pixel_row,
   output logic [ppdm_pkg::INDEX_W-1:0]              rsp_mapped_index,
   output logic signed [ppdm_pkg::DATA_W-1:0]        rsp_mapped_depth
);

   // sequencer state
   ppdm_pkg::state_type                 state_ff, state_in;
   logic [ppdm_pkg::CELL_AW-1:0]        clr_addr_ff, clr_addr_in;

   // captured request word
   logic                                cmd_ff, cmd_in;
   logic signed [ppdm_pkg::DATA_W-1:0]  v_ff, v_in;
   logic signed [ppdm_pkg::DATA_W-1:0]  w_ff, w_in;
   logic [ppdm_pkg::INDEX_W-1:0]        idx_ff, idx_in;
   logic                                col_neg_ff, col_neg_in;
   logic [ppdm_pkg::DATA_W-1:0]         col_mag_ff, col_mag_in;
   logic [ppdm_pkg::COL_W-1:0]          col_ff, col_in;
   logic [ppdm_pkg::ROW_W-1:0]          row_ff, row_in;
   logic [ppdm_pkg::CELL_AW-1:0]        addr_ff, addr_in;

   // pending result, handed to the output register in S_RESP
   ppdm_pkg::status_type                res_status_ff, res_status_in;
   logic [ppdm_pkg::COL_W-1:0]          res_col_ff, res_col_in;
   logic [ppdm_pkg::ROW_W-1:0]          res_row_ff, res_row_in;
   logic [ppdm_pkg::INDEX_W-1:0]        res_index_ff, res_index_in;
   logic signed [ppdm_pkg::DATA_W-1:0]  res_depth_ff, res_depth_in;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   ppdm_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic [ppdm_pkg::COL_W-1:0]          rsp_col_ff, rsp_col_in;
   logic [ppdm_pkg::ROW_W-1:0]          rsp_row_ff, rsp_row_in;
   logic [ppdm_pkg::INDEX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic signed [ppdm_pkg::DATA_W-1:0]  rsp_depth_ff, rsp_depth_in;

   // shared divider
   logic                                div_start;
   logic [ppdm_pkg::DATA_W-1:0]         div_dividend;
   logic [ppdm_pkg::DATA_W-1:0]         div_divisor;
   ppdm_pkg::div_status_type            div_stat;
   logic [ppdm_pkg::DATA_W-1:0]         div_quotient;

   // map memory
   logic                                ram_we;
   logic [ppdm_pkg::CELL_AW-1:0]        ram_wr_addr;
   ppdm_pkg::cell_type                  ram_wr_cell;
   logic                                ram_re;
   logic [ppdm_pkg::CELL_W-1:0]         ram_rd_data;
   ppdm_pkg::cell_type                  rd_cell;

   logic                                req_take;
   logic                                out_free;
   logic                                col_ok;
   logic                                row_ok;
   logic                                row_neg;

   assign req_take = req_valid && (state_ff == ppdm_pkg::S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_cell  = ppdm_pkg::cell_type'(ram_rd_data);
   assign row_neg  = v_ff[ppdm_pkg::DATA_W-1] ^ w_ff[ppdm_pkg::DATA_W-1];

   // a zero quotient is column zero whatever its sign
   assign col_ok = (col_mag_ff == '0) ||
                   (!col_neg_ff && (col_mag_ff < ppdm_pkg::DATA_W'(ppdm_pkg::FRAME_WIDTH)));
   assign row_ok = (div_quotient == '0) ||
                   (!row_neg && (div_quotient < ppdm_pkg::DATA_W'(ppdm_pkg::FRAME_HEIGHT)));

   ppdm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_stat),
      .quotient (div_quotient)
   );

   ppdm_ram #(
      .WIDTH (ppdm_pkg::CELL_W),
      .DEPTH (ppdm_pkg::CELL_COUNT)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_cell),
      .rd_en   (ram_re),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      cmd_in        = cmd_ff;
      v_in          = v_ff;
      w_in          = w_ff;
      idx_in        = idx_ff;
      col_neg_in    = col_neg_ff;
      col_mag_in    = col_mag_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      addr_in       = addr_ff;
      res_status_in = res_status_ff;
      res_col_in    = res_col_ff;
      res_row_in    = res_row_ff;
      res_index_in  = res_index_ff;
      res_depth_in  = res_depth_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_depth_in  = rsp_depth_ff;
      div_start     = 1'b0;
      div_dividend  = ppdm_pkg::magnitude(v_ff);
      div_divisor   = ppdm_pkg::magnitude(w_ff);
      ram_we        = 1'b0;
      ram_wr_addr   = addr_ff;
      ram_wr_cell   = '{valid: 1'b1, index: idx_ff, depth: w_ff};
      ram_re        = 1'b0;

      case (state_ff)
         ppdm_pkg::S_CLEAR: begin
            // sweep every pixel to empty
            ram_we      = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_cell = '0;
            clr_addr_in = clr_addr_ff + ppdm_pkg::CELL_AW'(1);
            if (clr_addr_ff == ppdm_pkg::CELL_AW'(ppdm_pkg::CELL_COUNT - 1)) begin
               state_in = ppdm_pkg::S_IDLE;
            end
         end
         ppdm_pkg::S_IDLE: begin
            if (req_take) begin
               cmd_in        = req_cmd;
               v_in          = req_proj_v;
               w_in          = req_proj_w;
               idx_in        = req_point_index;
               col_neg_in    = req_proj_u[ppdm_pkg::DATA_W-1] ^ req_proj_w[ppdm_pkg::DATA_W-1];
               col_in        = req_read_col;
               row_in        = req_read_row;
               res_status_in = ppdm_pkg::STATUS_OUT;
               res_col_in    = '0;
               res_row_in    = '0;
               res_index_in  = '0;
               res_depth_in  = '0;
               if (req_cmd == ppdm_pkg::CMD_READ) begin
                  if ((ppdm_pkg::DATA_W'(req_read_col) <
                       ppdm_pkg::DATA_W'(ppdm_pkg::FRAME_WIDTH)) &&
                      (ppdm_pkg::DATA_W'(req_read_row) <
                       ppdm_pkg::DATA_W'(ppdm_pkg::FRAME_HEIGHT))) begin
                     state_in = ppdm_pkg::S_ADDR;
                  end else begin
                     state_in = ppdm_pkg::S_RESP;
                  end
               end else if (!req_w_is_number || (req_proj_w == '0)) begin
                  res_status_in = ppdm_pkg::STATUS_BAD_W;
                  state_in      = ppdm_pkg::S_RESP;
               end else begin
                  // column quotient first
                  div_start    = 1'b1;
                  div_dividend = ppdm_pkg::magnitude(req_proj_u);
                  div_divisor  = ppdm_pkg::magnitude(req_proj_w);
                  state_in     = ppdm_pkg::S_DIV_COL;
               end
            end
         end
         ppdm_pkg::S_DIV_COL: begin
            if (div_stat.done) begin
               col_mag_in = div_quotient;
               div_start  = 1'b1;
               state_in   = ppdm_pkg::S_DIV_ROW;
            end
         end
         ppdm_pkg::S_DIV_ROW: begin
            if (div_stat.done) begin
               col_in = col_mag_ff[ppdm_pkg::COL_W-1:0];
               row_in = div_quotient[ppdm_pkg::ROW_W-1:0];
               if (col_ok && row_ok) begin
                  state_in = ppdm_pkg::S_ADDR;
               end else begin
                  state_in = ppdm_pkg::S_RESP;
               end
            end
         end
         ppdm_pkg::S_ADDR: begin
            addr_in  = ppdm_pkg::CELL_AW'(ppdm_pkg::CELL_AW'(row_ff) *
                                          ppdm_pkg::CELL_AW'(ppdm_pkg::FRAME_WIDTH))
                       + ppdm_pkg::CELL_AW'(col_ff);
            state_in = ppdm_pkg::S_READ;
         end
         ppdm_pkg::S_READ: begin
            ram_re   = 1'b1;
            state_in = ppdm_pkg::S_DECIDE;
         end
         ppdm_pkg::S_DECIDE: begin
            res_col_in = col_ff;
            res_row_in = row_ff;
            if (cmd_ff == ppdm_pkg::CMD_READ) begin
               if (rd_cell.valid) begin
                  res_status_in = ppdm_pkg::STATUS_READ_HIT;
                  res_index_in  = rd_cell.index;
                  res_depth_in  = rd_cell.depth;
               end else begin
                  res_status_in = ppdm_pkg::STATUS_READ_EMPTY;
                  res_index_in  = '0;
                  res_depth_in  = '0;
               end
            end else if (!rd_cell.valid || (rd_cell.depth > w_ff)) begin
               // empty pixel, or strictly nearer point
               ram_we = 1'b1;
               if (rd_cell.valid) begin
                  res_status_in = ppdm_pkg::STATUS_REPLACED;
               end else begin
                  res_status_in = ppdm_pkg::STATUS_FIRST;
               end
               res_index_in  = idx_ff;
               res_depth_in  = w_ff;
            end else begin
               res_status_in = ppdm_pkg::STATUS_KEPT;
               res_index_in  = rd_cell.index;
               res_depth_in  = rd_cell.depth;
            end
            state_in = ppdm_pkg::S_RESP;
         end
         ppdm_pkg::S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_col_in    = res_col_ff;
               rsp_row_in    = res_row_ff;
               rsp_index_in  = res_index_ff;
               rsp_depth_in  = res_depth_ff;
               state_in      = ppdm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ppdm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppdm_pkg::S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      v_ff          <= v_in;
      w_ff          <= w_in;
      idx_ff        <= idx_in;
      col_neg_ff    <= col_neg_in;
      col_mag_ff    <= col_mag_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      addr_ff       <= addr_in;
      res_status_ff <= res_status_in;
      res_col_ff    <= res_col_in;
      res_row_ff    <= res_row_in;
      res_index_ff  <= res_index_in;
      res_depth_ff  <= res_depth_in;
      rsp_status_ff <= rsp_status_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   assign req_stall        = !(state_ff == ppdm_pkg::S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_pixel_col    = rsp_col_ff;
   assign rsp_pixel_row    = rsp_row_ff;
   assign rsp_mapped_index = rsp_index_ff;
   assign rsp_mapped_depth = rsp_depth_ff;

`ifndef ASSERT_OFF
   // no response can appear while the map is still being swept
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ppdm_pkg::S_CLEAR) |-> !rsp_valid_ff)
      else $error("response word during clearing sweep");

   // map is written only by the sweep or the update step
   a_write_window: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ppdm_pkg::S_CLEAR) || (state_ff == ppdm_pkg::S_DECIDE)))
      else $error("map write outside sweep or update");

   // divider never restarted mid-run
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // a handed-over result shows up in the output register next cycle
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ppdm_pkg::S_RESP) && out_free) |=> rsp_valid_ff)
      else $error("result lost on hand-over");

   // responses always address a pixel inside the frame
   a_rsp_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((ppdm_pkg::DATA_W'(rsp_col_ff) <
                         ppdm_pkg::DATA_W'(ppdm_pkg::FRAME_WIDTH)) &&
                        (ppdm_pkg::DATA_W'(rsp_row_ff) <
                         ppdm_pkg::DATA_W'(ppdm_pkg::FRAME_HEIGHT))))
      else $error("response pixel outside frame");
`endif

endmodule
`default_nettype wire
